[design/s3mpu_pkg.sv]
package s3mpu_pkg;

    localparam int ROWS         = 64;
    localparam int CHANNEL_BITS = 5;
    localparam int ROW_W        = $clog2(ROWS + 1);

    localparam logic [7:0] NOTE_EMPTY = 8'd255;
    localparam logic [7:0] NOTE_CUT   = 8'd254;
    localparam logic [7:0] VOL_MAX    = 8'd64;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_HI,
        PH_FLAG,
        PH_NOTE,
        PH_INSTR,
        PH_VOL,
        PH_CMD,
        PH_PARAM
    } t_phase;

    typedef enum logic [1:0] {
        NK_ABSENT,
        NK_VALUE,
        NK_EMPTY,
        NK_CUT
    } t_note_kind;

    typedef struct packed {
        logic        has_event;
        logic [4:0]  channel;
        logic [5:0]  row;
        t_note_kind  note_kind;
        logic [7:0]  note_value;
        logic [7:0]  instrument;
        logic        volume_present;
        logic [6:0]  volume;
        logic        command_present;
        logic [7:0]  command;
        logic [7:0]  parameter_res;
        logic        pattern_end;
    } t_result;

endpackage

[design/s3m_pattern_unpacker.sv]
// a byte passes through the input register, then the decode stage, whose result is registered at the output
// throughput: one byte per cycle while the output is not stalled; a stalled result holds the decode stage,
// and the input register behind it absorbs one more byte
// reset: synchronous active low, returns to idle awaiting a pattern start,
// counters and held fields cleared
module s3m_pattern_unpacker
    import s3mpu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_pattern_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_has_event,
    output logic [4:0] o_channel,
    output logic [5:0] o_row,
    output logic [1:0] o_note_kind,
    output logic [7:0] o_note_value,
    output logic [7:0] o_instrument,
    output logic       o_volume_present,
    output logic [6:0] o_volume,
    output logic       o_command_present,
    output logic [7:0] o_command,
    output logic [7:0] o_parameter_res,
    output logic       o_pattern_end
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;

    t_phase           r_phase, n_phase;
    logic [15:0]      r_len, n_len;
    logic [16:0]      r_cnt, n_cnt;
    logic [ROW_W-1:0] r_row, n_row;
    logic [7:0]       r_flag, n_flag;
    logic [7:0]       r_note, n_note;
    t_note_kind       r_kind, n_kind;
    logic [7:0]       r_instr, n_instr;
    logic [6:0]       r_vol, n_vol;
    logic [7:0]       r_cmd, n_cmd;

    logic             r_out_valid;
    t_result          r_res, n_res;
    logic             n_emit;

    logic             w_out_free;
    logic             w_adv;
    logic             w_done;
    logic             w_row_step;
    logic             w_evt;
    logic [7:0]       w_param;
    t_note_kind       w_dec_kind;
    logic [7:0]       w_dec_value;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    s3mpu_note_dec u_note_dec (
        .i_byte  (r_in_byte),
        .o_kind  (w_dec_kind),
        .o_value (w_dec_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_pattern_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_row   <= '0;
            r_flag  <= '0;
            r_note  <= '0;
            r_kind  <= NK_ABSENT;
            r_instr <= '0;
            r_vol   <= '0;
            r_cmd   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_flag  <= n_flag;
            r_note  <= n_note;
            r_kind  <= n_kind;
            r_instr <= n_instr;
            r_vol   <= n_vol;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_flag     = r_flag;
        n_note     = r_note;
        n_kind     = r_kind;
        n_instr    = r_instr;
        n_vol      = r_vol;
        n_cmd      = r_cmd;
        n_emit     = 1'b0;
        n_res      = '0;
        w_row_step = 1'b0;
        w_evt      = 1'b0;
        w_param    = 8'd0;

        if (w_adv) begin
            if (r_in_start) begin
                n_len   = {8'h00, r_in_byte};
                n_cnt   = '0;
                n_row   = '0;
                n_flag  = '0;
                n_note  = '0;
                n_kind  = NK_ABSENT;
                n_instr = '0;
                n_vol   = '0;
                n_cmd   = '0;
                n_phase = PH_LEN_HI;
            end else begin
                if (r_phase != PH_IDLE && r_phase != PH_LEN_HI) begin
                    n_cnt = r_cnt + 17'd1;
                end
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_LEN_HI: begin
                        n_len   = {r_in_byte, r_len[7:0]};
                        n_phase = PH_FLAG;
                    end
                    PH_FLAG: begin
                        if (r_in_byte == 8'd0) begin
                            n_row      = r_row + ROW_W'(1);
                            w_row_step = 1'b1;
                        end else begin
                            n_flag  = r_in_byte;
                            n_note  = '0;
                            n_kind  = NK_ABSENT;
                            n_instr = '0;
                            n_vol   = '0;
                            n_cmd   = '0;
                            if (r_in_byte[5]) begin
                                n_phase = PH_NOTE;
                            end else if (r_in_byte[6]) begin
                                n_phase = PH_VOL;
                            end else if (r_in_byte[7]) begin
                                n_phase = PH_CMD;
                            end else begin
                                w_evt = 1'b1;
                            end
                        end
                    end
                    PH_NOTE: begin
                        n_kind  = w_dec_kind;
                        n_note  = w_dec_value;
                        n_phase = PH_INSTR;
                    end
                    PH_INSTR: begin
                        n_instr = r_in_byte - 8'd1;
                        if (r_flag[6]) begin
                            n_phase = PH_VOL;
                        end else if (r_flag[7]) begin
                            n_phase = PH_CMD;
                        end else begin
                            w_evt = 1'b1;
                        end
                    end
                    PH_VOL: begin
                        n_vol = (r_in_byte > VOL_MAX) ? VOL_MAX[6:0] : r_in_byte[6:0];
                        if (r_flag[7]) begin
                            n_phase = PH_CMD;
                        end else begin
                            w_evt = 1'b1;
                        end
                    end
                    PH_CMD: begin
                        n_cmd   = r_in_byte - 8'd1;
                        n_phase = PH_PARAM;
                    end
                    PH_PARAM: begin
                        w_param = r_in_byte;
                        w_evt   = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        // end of pattern, checked after the counters of this byte have moved
        w_done = (n_row >= ROW_W'(ROWS)) || (n_cnt > {1'b0, n_len});

        if (w_row_step && w_done) begin
            n_emit            = 1'b1;
            n_res.pattern_end = 1'b1;
            n_phase           = PH_IDLE;
        end

        if (w_evt) begin
            n_emit                = 1'b1;
            n_res.has_event       = 1'b1;
            n_res.channel         = 5'(n_flag[CHANNEL_BITS-1:0]);
            n_res.row             = n_row[5:0];
            n_res.note_kind       = n_kind;
            n_res.note_value      = n_note;
            n_res.instrument      = n_instr;
            n_res.volume_present  = n_flag[6];
            n_res.volume          = n_vol;
            n_res.command_present = n_flag[7];
            n_res.command         = n_cmd;
            n_res.parameter_res   = w_param;
            n_res.pattern_end     = w_done;
            n_phase               = w_done ? PH_IDLE : PH_FLAG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_has_event       = r_res.has_event;
    assign o_channel         = r_res.channel;
    assign o_row             = r_res.row;
    assign o_note_kind       = r_res.note_kind;
    assign o_note_value      = r_res.note_value;
    assign o_instrument      = r_res.instrument;
    assign o_volume_present  = r_res.volume_present;
    assign o_volume          = r_res.volume;
    assign o_command_present = r_res.command_present;
    assign o_command         = r_res.command;
    assign o_parameter_res   = r_res.parameter_res;
    assign o_pattern_end     = r_res.pattern_end;

endmodule

[design/s3mpu_note_dec.sv]
module s3mpu_note_dec
    import s3mpu_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_note_kind o_kind,
    output logic [7:0] o_value
);

    logic [7:0] w_oct;

    // octave times twelve as two shifts
    assign w_oct = {1'b0, i_byte[7:4], 3'b000} + {2'b00, i_byte[7:4], 2'b00};

    always_comb begin
        if (i_byte == NOTE_EMPTY) begin
            o_kind  = NK_EMPTY;
            o_value = 8'd0;
        end else if (i_byte == NOTE_CUT) begin
            o_kind  = NK_CUT;
            o_value = 8'd0;
        end else begin
            o_kind  = NK_VALUE;
            o_value = w_oct + {4'b0000, i_byte[3:0]};
        end
    end

endmodule

[design/s3mpu_checker.sv]
module s3mpu_checker
    import s3mpu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_has_event,
    input logic [4:0] o_channel,
    input logic [5:0] o_row,
    input logic [1:0] o_note_kind,
    input logic [7:0] o_note_value,
    input logic       o_volume_present,
    input logic [6:0] o_volume,
    input logic       o_command_present,
    input logic       o_pattern_end
);

    // a result without an event is only ever the end-of-pattern marker
    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_event |-> o_pattern_end && o_channel == 5'd0
            && o_note_kind == NK_ABSENT && !o_volume_present && !o_command_present)
        else $error("result without event is not a bare pattern end");

    a_vol_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_volume <= 7'd64 && (o_volume_present || o_volume == 7'd0))
        else $error("volume out of range or set while absent");

    a_note_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_note_kind != NK_VALUE |-> o_note_value == 8'd0)
        else $error("note value set for a non-value note");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_row)
            && $stable(o_channel) && $stable(o_pattern_end))
        else $error("stalled result changed");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output side is free");

endmodule

bind s3m_pattern_unpacker s3mpu_checker u_s3mpu_checker (.*);

[dv/testbench.sv]
module testbench;
    import s3mpu_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_pattern_start;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_has_event;
    logic [4:0] o_channel;
    logic [5:0] o_row;
    logic [1:0] o_note_kind;
    logic [7:0] o_note_value;
    logic [7:0] o_instrument;
    logic       o_volume_present;
    logic [6:0] o_volume;
    logic       o_command_present;
    logic [7:0] o_command;
    logic [7:0] o_parameter_res;
    logic       o_pattern_end;

    s3m_pattern_unpacker dut (.*);

    // decoder state mirrored on the testbench side
    t_phase     ph        = PH_IDLE;
    logic [15:0] pat_len  = '0;
    logic [16:0] pat_bytes = '0;
    logic [8:0] pat_row   = '0;
    logic [7:0] flag_q    = '0;
    logic [7:0] note_q    = '0;
    t_note_kind kind_q    = NK_ABSENT;
    logic [7:0] instr_q   = '0;
    logic [6:0] vol_q     = '0;
    logic [7:0] cmd_q     = '0;

    t_result pending_events[$];
    int      n_mismatch = 0;
    int      n_accepted = 0;
    bit      in_burst   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit pattern_over();
        return pat_row >= ROWS || pat_bytes > {1'b0, pat_len};
    endfunction

    function automatic void clear_held();
        note_q  = '0;
        kind_q  = NK_ABSENT;
        instr_q = '0;
        vol_q   = '0;
        cmd_q   = '0;
    endfunction

    function automatic bit emit_event(input logic [7:0] param, output t_result r);
        bit fin;
        fin = pattern_over();
        r = '0;
        r.has_event       = 1'b1;
        r.channel         = 5'(flag_q & ((1 << CHANNEL_BITS) - 1));
        r.row             = pat_row[5:0];
        r.note_kind       = kind_q;
        r.note_value      = note_q;
        r.instrument      = instr_q;
        r.volume_present  = flag_q[6];
        r.volume          = vol_q;
        r.command_present = flag_q[7];
        r.command         = cmd_q;
        r.parameter_res   = param;
        r.pattern_end     = fin;
        ph = fin ? PH_IDLE : PH_FLAG;
        return 1'b1;
    endfunction

    // move on to the next announced part of the group, or close it
    function automatic bit next_part(input t_phase done_part, output t_result r);
        r = '0;
        if (done_part < PH_VOL && flag_q[6]) begin
            ph = PH_VOL;
            return 1'b0;
        end
        if (done_part < PH_CMD && flag_q[7]) begin
            ph = PH_CMD;
            return 1'b0;
        end
        return emit_event(8'd0, r);
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output t_result r);
        r = '0;
        if (st) begin
            pat_len   = {8'd0, b};
            pat_bytes = '0;
            pat_row   = '0;
            flag_q    = '0;
            clear_held();
            ph = PH_LEN_HI;
            return 1'b0;
        end
        case (ph)
            PH_LEN_HI: begin
                pat_len[15:8] = b;
                ph = PH_FLAG;
                return 1'b0;
            end
            PH_FLAG: begin
                pat_bytes++;
                if (b == 8'd0) begin
                    pat_row++;
                    if (pattern_over()) begin
                        r.pattern_end = 1'b1;
                        ph = PH_IDLE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                flag_q = b;
                clear_held();
                if (b[5]) begin
                    ph = PH_NOTE;
                    return 1'b0;
                end
                return next_part(PH_INSTR, r);
            end
            PH_NOTE: begin
                pat_bytes++;
                if (b == NOTE_EMPTY) begin
                    kind_q = NK_EMPTY;
                    note_q = '0;
                end else if (b == NOTE_CUT) begin
                    kind_q = NK_CUT;
                    note_q = '0;
                end else begin
                    kind_q = NK_VALUE;
                    note_q = 8'(b[7:4] * 12 + b[3:0]);
                end
                ph = PH_INSTR;
                return 1'b0;
            end
            PH_INSTR: begin
                pat_bytes++;
                instr_q = 8'(b - 8'd1);
                return next_part(PH_INSTR, r);
            end
            PH_VOL: begin
                pat_bytes++;
                vol_q = (b > VOL_MAX) ? VOL_MAX[6:0] : b[6:0];
                return next_part(PH_VOL, r);
            end
            PH_CMD: begin
                pat_bytes++;
                cmd_q = 8'(b - 8'd1);
                ph = PH_PARAM;
                return 1'b0;
            end
            PH_PARAM: begin
                pat_bytes++;
                return emit_event(b, r);
            end
            default: begin
                ph = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic string show(input t_result r);
        return $sformatf({"ev=%0b ch=%0d row=%0d kind=%0d note=%0d ins=%0d ",
                          "vp=%0b vol=%0d cp=%0b cmd=%0d par=%0d end=%0b"},
                         r.has_event, r.channel, r.row, r.note_kind, r.note_value,
                         r.instrument, r.volume_present, r.volume, r.command_present,
                         r.command, r.parameter_res, r.pattern_end);
    endfunction

    // input transactions feed the decoder, output transactions are checked in order
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            n_accepted++;
            if (decode_byte(i_data_byte, i_pattern_start, want))
                pending_events.push_back(want);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_has_event, o_channel, o_row, o_note_kind, o_note_value, o_instrument,
                   o_volume_present, o_volume, o_command_present, o_command,
                   o_parameter_res, o_pattern_end};
            if (pending_events.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: actual %s", show(got));
            end else begin
                want = pending_events.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result differs\n  expected %s\n  actual   %s",
                                 show(want), show(got));
                end
            end
        end
    end

    initial begin : out_stall_gen
        int hold;
        bit quiet_run;
        hold = 0;
        quiet_run = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 29) == 0) quiet_run = !quiet_run;
                hold = quiet_run ? 0 : $urandom_range(0, 10);
            end else if (hold > 0) begin
                hold--;
            end
            i_out_stall <= (hold > 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_pattern_start <= st;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_group(input logic [7:0] flag);
        logic [7:0] nb;
        send_byte(flag, 1'b0);
        if (flag[5]) begin
            case ($urandom_range(0, 9))
                0:       nb = NOTE_EMPTY;
                1:       nb = NOTE_CUT;
                default: nb = 8'($urandom);
            endcase
            send_byte(nb, 1'b0);
            send_byte(8'($urandom), 1'b0);
        end
        // volume mostly around the clip point
        if (flag[6])
            send_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(60, 68)),
                      1'b0);
        if (flag[7]) begin
            send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic send_pattern(input logic [15:0] len, input int rows, input int max_ev);
        int nev;
        send_byte(len[7:0], 1'b1);
        send_byte(len[15:8], 1'b0);
        for (int r = 0; r < rows; r++) begin
            nev = $urandom_range(0, max_ev);
            for (int e = 0; e < nev; e++) send_group(8'($urandom_range(1, 255)));
            send_byte(8'd0, 1'b0);
        end
    endtask

    task automatic test_directed();
        send_byte(8'h5A, 1'b0);     // nothing open yet, ignored
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        // channel 31 with every part: empty note, wrapped instrument and command
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // channel 0, cut note, volume right at the limit
        send_byte(8'hE0, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);     // flag with no data bits
        send_byte(8'h00, 1'b0);
        // restart part way through a group, then end on the byte count
        send_byte(8'h85, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);     // after the end, ignored
        // zero length: the first event closes the pattern
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5F, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_row_limit();
        send_pattern(16'hFFFF, 66, 1);
        send_pattern(16'($urandom_range(16'h8000, 16'hFFFE)), 65, 1);
    endtask

    task automatic test_length_limit();
        repeat (8) send_pattern(16'($urandom_range(0, 30)), $urandom_range(2, 12), 3);
    endtask

    task automatic test_random_streams();
        int n;
        while (n_accepted < 850) begin
            case ($urandom_range(0, 9))
                7: send_pattern($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(64, 400)),
                                $urandom_range(62, 66), 1);
                8: begin
                    // broken pattern: a group cut short by the next start
                    send_byte(8'($urandom), 1'b1);
                    send_byte(8'($urandom), 1'b0);
                    send_byte(8'($urandom_range(8'h21, 8'hFF)), 1'b0);
                    if ($urandom_range(0, 1)) send_byte(8'($urandom), 1'b0);
                end
                9: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
                default: send_pattern($urandom_range(0, 3) == 0 ? 16'($urandom)
                                                                : 16'($urandom_range(0, 60)),
                                      $urandom_range(1, 10), 3);
            endcase
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_data_byte     <= 8'd0;
        i_pattern_start <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_row_limit();
        test_length_limit();
        test_random_streams();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
design/s3mpu_pkg.sv
design/s3mpu_note_dec.sv
design/s3m_pattern_unpacker.sv
design/s3mpu_checker.sv
dv/testbench.sv
